[hw/rtl/bpw_pkg.sv]
// Package for the BSP point leaf walk unit.
// Holds node entry layout, op and status codes, sequencer states and dot unit controls.
// No dependencies.
package bpw_pkg;

	// Field widths fixed by the interface
	localparam int NORMAL_W = 16;
	localparam int COORD_W  = 24;
	localparam int CHILD_W  = 17;
	localparam int COUNT_W  = 13;
	localparam int LEAF_W   = 16;
	localparam int STEPS_W  = 7;
	localparam int INDEX_W  = 12;
	localparam int PROD_W   = COORD_W + NORMAL_W;
	localparam int ACC_W    = PROD_W + 3;
	localparam int DIST_SHIFT = 15;

	// Operation codes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Result status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NO_TREE = 2'd1;
	localparam logic [1:0] STAT_CHILD   = 2'd2;
	localparam logic [1:0] STAT_DEPTH   = 2'd3;

	// One tree node as stored
	typedef struct packed {
		logic signed [NORMAL_W-1:0] normal_x;
		logic signed [NORMAL_W-1:0] normal_y;
		logic signed [NORMAL_W-1:0] normal_z;
		logic signed [COORD_W-1:0]  plane_dist;
		logic signed [CHILD_W-1:0]  front_child;
		logic signed [CHILD_W-1:0]  back_child;
	} node_t;

	// Walk sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL_X,
		ST_MUL_Y,
		ST_MUL_Z,
		ST_ACC,
		ST_DECIDE
	} walk_state_t;

	// Operand select of the shared multiplier
	typedef enum logic [1:0] {
		SEL_X,
		SEL_Y,
		SEL_Z
	} dot_sel_t;

	// Controls from the sequencer to the dot unit
	typedef struct packed {
		logic     mul_en;
		dot_sel_t sel;
		logic     acc_load;
		logic     acc_add;
	} dot_ctrl_t;

endpackage

[hw/rtl/bsp_point_leaf_walk_unit.sv]
// BSP point leaf walk unit, top level: command port, node memory, walk sequencer.
// Depends on bpw_pkg, bpw_node_mem and bpw_dot_unit.
//
// A load command (op 0) writes one node in the cycle it is taken and yields no result.
// A query command (op 1) walks the tree from node zero. Each level runs through a node
// memory read, the x, y and z products of the single shared 24x16 multiplier, a final
// accumulate and a decision; busy holds for the whole walk, and the query's result strobes
// on done in the same cycle that busy falls. An empty tree answers in the cycle after the
// query is taken, without going busy. done is high for exactly one cycle and the receiver
// cannot stall it, so results must be captured when they appear. node_count is
// written through the cfg port while busy is low.
module bsp_point_leaf_walk_unit #(
	parameter int NODE_CAPACITY = 4096,
	parameter int LEAF_CAPACITY = 65536,
	parameter int MAX_DEPTH     = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bpw_pkg::COUNT_W-1:0]          cfg_data,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 op,
	input  logic [bpw_pkg::INDEX_W-1:0]          node_index,
	input  logic signed [bpw_pkg::NORMAL_W-1:0]  normal_x,
	input  logic signed [bpw_pkg::NORMAL_W-1:0]  normal_y,
	input  logic signed [bpw_pkg::NORMAL_W-1:0]  normal_z,
	input  logic signed [bpw_pkg::COORD_W-1:0]   plane_dist,
	input  logic signed [bpw_pkg::CHILD_W-1:0]   front_child,
	input  logic signed [bpw_pkg::CHILD_W-1:0]   back_child,
	input  logic signed [bpw_pkg::COORD_W-1:0]   point_x,
	input  logic signed [bpw_pkg::COORD_W-1:0]   point_y,
	input  logic signed [bpw_pkg::COORD_W-1:0]   point_z,
	output logic                                 done,
	output logic [bpw_pkg::LEAF_W-1:0]           leaf_index,
	output logic [bpw_pkg::STEPS_W-1:0]          walk_steps,
	output logic [1:0]                           status
);
	import bpw_pkg::*;

	localparam int AW  = (NODE_CAPACITY > 1) ? $clog2(NODE_CAPACITY) : 1;
	localparam int CW  = 17;
	localparam logic [CW-1:0] CAP_COUNT = CW'(NODE_CAPACITY);
	localparam logic [STEPS_W-1:0] DEPTH_LIMIT = STEPS_W'(MAX_DEPTH);

	walk_state_t state_q, state_d;
	dot_ctrl_t   dot_ctrl;
	node_t       wr_node, rd_node;

	logic [COUNT_W-1:0]        node_count_q;
	logic [CW-1:0]             count_eff;
	logic [AW-1:0]             node_q;
	logic [STEPS_W-1:0]        steps_q;
	logic [STEPS_W-1:0]        steps_inc;
	logic signed [COORD_W-1:0] px_q, py_q, pz_q;
	logic                      mem_re;
	logic                      load_we;
	logic                      accept;
	logic                      front;

	logic                      done_q;
	logic [LEAF_W-1:0]         leaf_q;
	logic [STEPS_W-1:0]        steps_out_q;
	logic [1:0]                status_q;

	// Decision signals
	logic signed [CHILD_W-1:0] child;
	logic                      child_leaf;
	logic [LEAF_W-1:0]         leaf_val;
	logic                      child_bad;
	logic                      leaf_bad;
	logic                      go_on;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = !busy;

	// Clamp the node count to the memory depth
	assign count_eff = (CW'(node_count_q) > CAP_COUNT) ? CAP_COUNT : CW'(node_count_q);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			node_count_q <= cfg_data;
		end
	end

	// Node writes go straight to memory; drop slots beyond the depth
	assign load_we = accept && (op == OP_LOAD) && (32'(node_index) < NODE_CAPACITY);

	always_comb begin
		wr_node.normal_x    = normal_x;
		wr_node.normal_y    = normal_y;
		wr_node.normal_z    = normal_z;
		wr_node.plane_dist  = plane_dist;
		wr_node.front_child = front_child;
		wr_node.back_child  = back_child;
	end

	bpw_node_mem #(
		.DEPTH(NODE_CAPACITY),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (load_we),
		.waddr(AW'(node_index)),
		.wdata(wr_node),
		.re   (mem_re),
		.raddr(node_q),
		.rdata(rd_node)
	);

	bpw_dot_unit u_dot (
		.clk  (clk),
		.ctrl (dot_ctrl),
		.px   (px_q),
		.py   (py_q),
		.pz   (pz_q),
		.node (rd_node),
		.front(front)
	);

	// Pick the child and classify it
	assign steps_inc  = steps_q + 1'b1;
	assign child      = front ? rd_node.front_child : rd_node.back_child;
	assign child_leaf = child[CHILD_W-1];
	assign leaf_val   = ~child[LEAF_W-1:0];
	assign leaf_bad   = (32'(leaf_val) >= LEAF_CAPACITY);
	assign child_bad  = (CW'(child[LEAF_W-1:0]) >= count_eff);
	assign go_on      = !child_leaf && !child_bad && (steps_inc < DEPTH_LIMIT);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (op == OP_QUERY) && (count_eff != '0)) begin
					state_d = ST_READ;
				end
			end
			ST_READ:   state_d = ST_MUL_X;
			ST_MUL_X:  state_d = ST_MUL_Y;
			ST_MUL_Y:  state_d = ST_MUL_Z;
			ST_MUL_Z:  state_d = ST_ACC;
			ST_ACC:    state_d = ST_DECIDE;
			ST_DECIDE: state_d = go_on ? ST_READ : ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		mem_re            = 1'b0;
		dot_ctrl.mul_en   = 1'b0;
		dot_ctrl.sel      = SEL_X;
		dot_ctrl.acc_load = 1'b0;
		dot_ctrl.acc_add  = 1'b0;
		case (state_q)
			ST_READ: begin
				mem_re = 1'b1;
			end
			ST_MUL_X: begin
				dot_ctrl.mul_en = 1'b1;
				dot_ctrl.sel    = SEL_X;
			end
			ST_MUL_Y: begin
				dot_ctrl.mul_en   = 1'b1;
				dot_ctrl.sel      = SEL_Y;
				dot_ctrl.acc_load = 1'b1;
			end
			ST_MUL_Z: begin
				dot_ctrl.mul_en  = 1'b1;
				dot_ctrl.sel     = SEL_Z;
				dot_ctrl.acc_add = 1'b1;
			end
			ST_ACC: begin
				dot_ctrl.acc_add = 1'b1;
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Walk position and query point
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			node_q  <= '0;
			steps_q <= '0;
			px_q    <= point_x;
			py_q    <= point_y;
			pz_q    <= point_z;
		end else if (state_q == ST_DECIDE) begin
			node_q  <= AW'(child[LEAF_W-1:0]);
			steps_q <= steps_inc;
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_IDLE && accept && op == OP_QUERY && count_eff == '0)
				|| (state_q == ST_DECIDE && !go_on);
		end
	end

	// Result fields
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			leaf_q      <= '0;
			steps_out_q <= '0;
			status_q    <= STAT_NO_TREE;
		end else if (state_q == ST_DECIDE) begin
			steps_out_q <= steps_inc;
			if (child_leaf) begin
				leaf_q   <= leaf_bad ? '0 : leaf_val;
				status_q <= leaf_bad ? STAT_CHILD : STAT_OK;
			end else if (child_bad) begin
				leaf_q   <= '0;
				status_q <= STAT_CHILD;
			end else begin
				leaf_q   <= '0;
				status_q <= STAT_DEPTH;
			end
		end
	end

	assign done       = done_q;
	assign leaf_index = leaf_q;
	assign walk_steps = steps_out_q;
	assign status     = status_q;

endmodule

[hw/rtl/bpw_node_mem.sv]
// Node memory of the BSP point leaf walk unit: one write port, one registered read port.
// Depends on bpw_pkg for the node entry layout.
module bpw_node_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  bpw_pkg::node_t  wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output bpw_pkg::node_t  rdata
);
	import bpw_pkg::*;

	node_t mem [DEPTH];
	node_t rdata_q;

	// Write one node per beat
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read and hold until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/bpw_dot_unit.sv]
// Shared multiply-accumulate unit: plane distance of a point, one product per cycle while mul_en is high.
// Depends on bpw_pkg for widths and the control struct.
module bpw_dot_unit (
	input  logic                                clk,
	input  bpw_pkg::dot_ctrl_t                  ctrl,
	input  logic signed [bpw_pkg::COORD_W-1:0]  px,
	input  logic signed [bpw_pkg::COORD_W-1:0]  py,
	input  logic signed [bpw_pkg::COORD_W-1:0]  pz,
	input  bpw_pkg::node_t                      node,
	output logic                                front
);
	import bpw_pkg::*;

	logic signed [COORD_W-1:0]  op_p;
	logic signed [NORMAL_W-1:0] op_n;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [ACC_W-1:0]    prod_ext;
	logic signed [ACC_W-1:0]    dist_ext;

	// Pick the coordinate and normal component for this cycle
	always_comb begin
		case (ctrl.sel)
			SEL_X: begin
				op_p = px;
				op_n = node.normal_x;
			end
			SEL_Y: begin
				op_p = py;
				op_n = node.normal_y;
			end
			SEL_Z: begin
				op_p = pz;
				op_n = node.normal_z;
			end
			default: begin
				op_p = px;
				op_n = node.normal_x;
			end
		endcase
	end

	assign prod_ext = ACC_W'(prod_q);
	assign dist_ext = ACC_W'(node.plane_dist) <<< DIST_SHIFT;

	// Register each product, then fold it into the sum
	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_q <= op_p * op_n;
		end
		if (ctrl.acc_load) begin
			acc_q <= prod_ext - dist_ext;
		end else if (ctrl.acc_add) begin
			acc_q <= acc_q + prod_ext;
		end
	end

	// Front side when the signed distance is above zero
	assign front = !acc_q[ACC_W-1] && (acc_q != '0);

endmodule

[hw/rtl/bpw_checker.sv]
// Port-level checks for the BSP point leaf walk unit, and the bind that attaches them.
// Depends on bpw_pkg for status and op codes.
module bpw_checker #(
	parameter int MAX_DEPTH = 64
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          op,
	input logic                          done,
	input logic [bpw_pkg::LEAF_W-1:0]    leaf_index,
	input logic [bpw_pkg::STEPS_W-1:0]   walk_steps,
	input logic [1:0]                    status
);
	import bpw_pkg::*;

	localparam logic [STEPS_W-1:0] DEPTH_LIMIT = STEPS_W'(MAX_DEPTH);

	// A load beat taken while idle yields no result beat
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op == OP_LOAD) |=> !done)
		else $error("result beat after a load");

	// Any error clears the leaf index
	a_error_leaf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != STAT_OK) |-> (leaf_index == '0))
		else $error("nonzero leaf on error");

	// Empty tree visits nothing
	a_no_tree_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_NO_TREE) |-> (walk_steps == '0))
		else $error("steps counted without a tree");

	// Depth error reports the full depth
	a_depth_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_DEPTH) |-> (walk_steps == DEPTH_LIMIT))
		else $error("depth error with wrong step count");

	// A walk that ran visits at least one node and no more than the limit
	a_steps_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == STAT_OK || status == STAT_CHILD))
		|-> (walk_steps != '0 && walk_steps <= DEPTH_LIMIT))
		else $error("step count out of range");

endmodule

bind bsp_point_leaf_walk_unit bpw_checker #(
	.MAX_DEPTH(MAX_DEPTH)
) u_bpw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.op        (op),
	.done      (done),
	.leaf_index(leaf_index),
	.walk_steps(walk_steps),
	.status    (status)
);

[test/bsp_point_leaf_walk_unit_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for bsp_point_leaf_walk_unit: node loads and point queries
// checked against a scoreboard that walks its own copy of the BSP node table.
// Depends on bpw_pkg and the bsp_point_leaf_walk_unit RTL.
module bsp_point_leaf_walk_unit_test;
	import bpw_pkg::*;

	localparam int NODES       = 4096;
	localparam int LEAVES      = 65536;
	localparam int DEPTH_LIMIT = 64;
	localparam int COUNT_MAX   = 8191;
	localparam int QUIET_CYCLES = 8;
	localparam int RANDOM_ITEMS = 1950;

	// One command beat as driven on the port
	typedef struct {
		logic                       op;
		logic [INDEX_W-1:0]         node_index;
		logic signed [NORMAL_W-1:0] normal_x;
		logic signed [NORMAL_W-1:0] normal_y;
		logic signed [NORMAL_W-1:0] normal_z;
		logic signed [COORD_W-1:0]  plane_dist;
		logic signed [CHILD_W-1:0]  front_child;
		logic signed [CHILD_W-1:0]  back_child;
		logic signed [COORD_W-1:0]  point_x;
		logic signed [COORD_W-1:0]  point_y;
		logic signed [COORD_W-1:0]  point_z;
	} walk_cmd_t;

	// One answer to a point query
	typedef struct {
		logic [LEAF_W-1:0]  leaf;
		logic [STEPS_W-1:0] steps;
		logic [1:0]         status;
	} leaf_answer_t;

	// Mirror of the node table; predicts the leaf for each accepted query
	class leaf_walk_board;
		node_t          nodes [NODES];
		int             node_count;
		leaf_answer_t   expected_leaves [$];
		int             mismatches;

		function new();
			node_count = 0;
			mismatches = 0;
		endfunction

		function void set_count(int value);
			node_count = value;
		endfunction

		function int pending();
			return expected_leaves.size();
		endfunction

		function void take_command(walk_cmd_t c);
			leaf_answer_t ans;
			node_t        e;
			int           live, node, steps, child, leaf;
			longint       px, py, pz, side;
			bit           settled;
			// Loads only update the table
			if (c.op == OP_LOAD) begin
				e.normal_x    = c.normal_x;
				e.normal_y    = c.normal_y;
				e.normal_z    = c.normal_z;
				e.plane_dist  = c.plane_dist;
				e.front_child = c.front_child;
				e.back_child  = c.back_child;
				nodes[c.node_index] = e;
				return;
			end
			live = (node_count > NODES) ? NODES : node_count;
			ans.leaf = '0;
			ans.steps = '0;
			ans.status = STAT_OK;
			if (live == 0) begin
				ans.status = STAT_NO_TREE;
			end else begin
				px = $signed(c.point_x);
				py = $signed(c.point_y);
				pz = $signed(c.point_z);
				node = 0;
				steps = 0;
				settled = 0;
				// Walk from node zero until a leaf, a bad child or the depth limit
				while (!settled) begin
					if (steps >= DEPTH_LIMIT) begin
						ans.status = STAT_DEPTH;
						settled = 1;
					end else begin
						steps++;
						e = nodes[node];
						side = px * $signed(e.normal_x) + py * $signed(e.normal_y)
							+ pz * $signed(e.normal_z)
							- longint'($signed(e.plane_dist)) * 32768;
						child = (side > 0) ? $signed(e.front_child) : $signed(e.back_child);
						if (child >= 0) begin
							if (child >= live) begin
								ans.status = STAT_CHILD;
								settled = 1;
							end else begin
								node = child;
							end
						end else begin
							leaf = -1 - child;
							if (leaf >= LEAVES)
								ans.status = STAT_CHILD;
							else
								ans.leaf = LEAF_W'(leaf);
							settled = 1;
						end
					end
				end
				ans.steps = STEPS_W'(steps);
			end
			expected_leaves.push_back(ans);
		endfunction

		function void check_result(logic [LEAF_W-1:0] leaf, logic [STEPS_W-1:0] steps,
				logic [1:0] status);
			leaf_answer_t want;
			if (expected_leaves.size() == 0) begin
				$error("done strobe with no query outstanding");
				mismatches++;
				return;
			end
			want = expected_leaves.pop_front();
			if (leaf !== want.leaf) begin
				$error("leaf_index: expected %0d, got %0d", want.leaf, leaf);
				mismatches++;
			end
			if (steps !== want.steps) begin
				$error("walk_steps: expected %0d, got %0d", want.steps, steps);
				mismatches++;
			end
			if (status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, status);
				mismatches++;
			end
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [COUNT_W-1:0]         cfg_data;
	logic                       start;
	logic                       busy;
	logic                       op;
	logic [INDEX_W-1:0]         node_index;
	logic signed [NORMAL_W-1:0] normal_x;
	logic signed [NORMAL_W-1:0] normal_y;
	logic signed [NORMAL_W-1:0] normal_z;
	logic signed [COORD_W-1:0]  plane_dist;
	logic signed [CHILD_W-1:0]  front_child;
	logic signed [CHILD_W-1:0]  back_child;
	logic signed [COORD_W-1:0]  point_x;
	logic signed [COORD_W-1:0]  point_y;
	logic signed [COORD_W-1:0]  point_z;
	logic                       done;
	logic [LEAF_W-1:0]          leaf_index;
	logic [STEPS_W-1:0]         walk_steps;
	logic [1:0]                 status;

	leaf_walk_board board = new();

	bsp_point_leaf_walk_unit #(
		.NODE_CAPACITY(NODES),
		.LEAF_CAPACITY(LEAVES),
		.MAX_DEPTH(DEPTH_LIMIT)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.op(op),
		.node_index(node_index),
		.normal_x(normal_x),
		.normal_y(normal_y),
		.normal_z(normal_z),
		.plane_dist(plane_dist),
		.front_child(front_child),
		.back_child(back_child),
		.point_x(point_x),
		.point_y(point_y),
		.point_z(point_z),
		.done(done),
		.leaf_index(leaf_index),
		.walk_steps(walk_steps),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Check every answer in the cycle it strobes
	always @(posedge clk) begin
		if (done === 1'b1)
			board.check_result(leaf_index, walk_steps, status);
	end

	// Fill every field at random; callers override what matters
	function automatic walk_cmd_t random_command();
		walk_cmd_t c;
		c.op          = OP_QUERY;
		c.node_index  = INDEX_W'($urandom);
		c.normal_x    = NORMAL_W'($urandom);
		c.normal_y    = NORMAL_W'($urandom);
		c.normal_z    = NORMAL_W'($urandom);
		c.plane_dist  = COORD_W'($urandom);
		c.front_child = CHILD_W'($urandom);
		c.back_child  = CHILD_W'($urandom);
		c.point_x     = COORD_W'($urandom);
		c.point_y     = COORD_W'($urandom);
		c.point_z     = COORD_W'($urandom);
		return c;
	endfunction

	function automatic walk_cmd_t node_load(int slot, int nx, int ny, int nz, int plane_d,
			int front, int back);
		walk_cmd_t c;
		c = random_command();
		c.op          = OP_LOAD;
		c.node_index  = INDEX_W'(slot);
		c.normal_x    = NORMAL_W'(nx);
		c.normal_y    = NORMAL_W'(ny);
		c.normal_z    = NORMAL_W'(nz);
		c.plane_dist  = COORD_W'(plane_d);
		c.front_child = CHILD_W'(front);
		c.back_child  = CHILD_W'(back);
		return c;
	endfunction

	function automatic walk_cmd_t point_query(int px, int py, int pz);
		walk_cmd_t c;
		c = random_command();
		c.op      = OP_QUERY;
		c.point_x = COORD_W'(px);
		c.point_y = COORD_W'(py);
		c.point_z = COORD_W'(pz);
		return c;
	endfunction

	// Child for node k of an n-node tree; never names an unloaded slot below live
	function automatic int pick_child(int n, int live, int k);
		int r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return $urandom_range(0, n - 1);
		if (r < 20)
			return $urandom_range(live, 65535);
		if (r < 60 && k < n - 1)
			return (r < 35) ? k + 1 : $urandom_range(k + 1, n - 1);
		return -1 - $urandom_range(0, 65535);
	endfunction

	// Hold start low for the given gap, then present one beat until it is taken
	task automatic issue(input walk_cmd_t c, input int gap);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start       <= 1'b1;
		op          <= c.op;
		node_index  <= c.node_index;
		normal_x    <= c.normal_x;
		normal_y    <= c.normal_y;
		normal_z    <= c.normal_z;
		plane_dist  <= c.plane_dist;
		front_child <= c.front_child;
		back_child  <= c.back_child;
		point_x     <= c.point_x;
		point_y     <= c.point_y;
		point_z     <= c.point_z;
		do @(posedge clk); while (busy !== 1'b0);
		board.take_command(c);
	endtask

	// Drop start and wait until every answer is in and the block is quiet
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(input int value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= COUNT_W'(value);
		do @(posedge clk); while (cfg_ready !== 1'b1);
		board.set_count(value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int n, count, live, pick, burst, items, beats, slot, px, py, pz;
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		start       = 1'b0;
		op          = OP_LOAD;
		node_index  = '0;
		normal_x    = '0;
		normal_y    = '0;
		normal_z    = '0;
		plane_dist  = '0;
		front_child = '0;
		back_child  = '0;
		point_x     = '0;
		point_y     = '0;
		point_z     = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: empty tree straight out of reset
		issue(point_query(0, 0, 0), 0);
		// Four-node tree: x split, zero plane, extreme plane, z split with a self loop
		issue(node_load(0, 32767, 0, 0, 0, 1, -65536), $urandom_range(0, 4));
		issue(node_load(1, 0, 0, 0, 0, -1, 2), $urandom_range(0, 4));
		issue(node_load(2, -32768, -32768, -32768, 8388607, 65535, 3), $urandom_range(0, 4));
		issue(node_load(3, 0, 0, 32767, 0, -1, 3), $urandom_range(0, 4));
		issue(node_load(4095, 32767, 32767, 32767, -8388608, 65535, -65536), 0);
		settle();
		write_count(4);
		issue(point_query(-1, 0, 0), $urandom_range(0, 4));
		issue(point_query(0, 0, 0), $urandom_range(0, 4));
		issue(point_query(1, -8388608, -8388608), $urandom_range(0, 4));
		issue(point_query(8388607, 8388607, 8388607), 0);
		issue(point_query(1, 0, -8388608), 0);
		settle();
		write_count(1);
		issue(point_query(1, 0, 0), $urandom_range(0, 4));
		issue(point_query(-8388608, 8388607, 8388607), $urandom_range(0, 4));
		settle();
		write_count(COUNT_MAX);
		issue(point_query(1, -8388608, -8388608), 0);
		issue(point_query(1, 0, 0), 0);
		settle();
		write_count(NODES);
		issue(point_query(8388607, 8388607, 8388607), $urandom_range(0, 4));
		settle();
		write_count(0);
		issue(point_query(8388607, -8388608, 1), $urandom_range(0, 4));
		settle();

		// Random phases: build a fresh tree, set the count, then mix queries and loads
		items = 0;
		while (items < RANDOM_ITEMS) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 24);
			pick = $urandom_range(0, 99);
			if (pick < 60)
				count = n;
			else if (pick < 70)
				count = 0;
			else if (pick < 78)
				count = $urandom_range(1, n);
			else if (pick < 86)
				count = $urandom_range(n, COUNT_MAX);
			else if (pick < 93)
				count = COUNT_MAX;
			else
				count = NODES;
			live = (count > NODES) ? NODES : count;
			burst = ($urandom_range(0, 3) == 0);

			for (int k = 0; k < n; k++)
				issue(node_load(k, $urandom, $urandom, $urandom, $urandom,
					pick_child(n, live, k), pick_child(n, live, k)),
					burst ? 0 : $urandom_range(0, 4));
			settle();
			write_count(count);

			beats = $urandom_range(40, 120);
			for (int j = 0; j < beats; j++) begin
				// Now and then let the pipe run dry before the next beat
				if ($urandom_range(0, 63) == 0)
					settle();
				if ($urandom_range(0, 3) == 0) begin
					slot = ($urandom_range(0, 2) == 0) ? $urandom_range(0, NODES - 1)
						: $urandom_range(0, n - 1);
					issue(node_load(slot, $urandom, $urandom, $urandom, $urandom,
						pick_child(n, live, slot), pick_child(n, live, slot)),
						burst ? 0 : $urandom_range(0, 4));
				end else begin
					px = $urandom;
					py = $urandom;
					pz = $urandom;
					if ($urandom_range(0, 15) == 0) begin
						px = $urandom_range(0, 1) ? 8388607 : -8388608;
						py = $urandom_range(0, 1) ? 8388607 : -8388608;
						pz = $urandom_range(0, 1) ? 8388607 : -8388608;
					end
					issue(point_query(px, py, pz), burst ? 0 : $urandom_range(0, 4));
				end
			end
			settle();
			items += n + beats;
		end

		repeat (QUIET_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("** bsp_point_leaf_walk_unit: PASSED **");
		else
			$display("** bsp_point_leaf_walk_unit: FAILED **");
		$finish;
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#100_000_000;
		$display("** bsp_point_leaf_walk_unit: FAILED **");
		$finish;
	end

endmodule
